@@ hdl/utf8sf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, byte constants and a helper function for the UTF-8 sanitizing filter.
// Used by utf8sf_scan, utf8sf_emit and the top level; depends on nothing else.
package utf8sf_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int LEN_WIDTH       = 24;
  localparam int MAX_DATA        = 4;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_CONT_LO = 8'hA0;
  localparam logic [7:0] ED_CONT_HI = 8'h9F;
  localparam logic [7:0] F0_CONT_LO = 8'h90;
  localparam logic [7:0] F4_CONT_HI = 8'h8F;

  // One input's worth of results: released data bytes and an optional end marker.
  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [2:0]               n_data;
    logic                     end_mark;
  } batch_t;

  // Total length of the sequence that a byte opens; 1 when it is no lead byte.
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd1;
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) begin
      len = 3'd2;
    end else if (lead >= LEAD_E0 && lead < LEAD_F0) begin
      len = 3'd3;
    end else if (lead >= LEAD_F0 && lead <= LEAD_F4) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

@@ hdl/utf8_sanitize_filter_core.sv @@
`timescale 1ns / 1ps
// Top level of the streaming UTF-8 sanitizing filter.
// Depends on utf8sf_pkg, utf8sf_scan and utf8sf_emit.

// One text byte is taken per transaction and decided once the result register
// is free; an input byte that releases 0 to 5 results (up to four bytes of a
// completed sequence plus the end marker on the last byte of a text) holds
// the result register until they are taken, one result per cycle while the
// result side does not stall; a byte that releases nothing, or one, then
// keeps the input side at one transaction per clock. The input register takes
// a new byte while the result register still waits, and the input stalls
// only when both are occupied. No clearing pass is needed after reset.
module utf8_sanitize_filter_core #(
  parameter int COUNT_WIDTH = utf8sf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  output logic                             byte_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             text_end,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       out_byte,
  output logic                             kind,
  output logic [utf8sf_pkg::LEN_WIDTH-1:0] written_length,
  output logic                             run_last
);

  logic                   emit_free;
  logic                   load;
  utf8sf_pkg::batch_t     batch;
  logic [COUNT_WIDTH-1:0] base;

  utf8sf_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .in_byte   (in_byte),
    .text_end  (text_end),
    .emit_free (emit_free),
    .load      (load),
    .batch     (batch),
    .base      (base)
  );

  utf8sf_emit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .batch         (batch),
    .base          (base),
    .emit_free     (emit_free),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .kind          (kind),
    .written_length(written_length),
    .run_last      (run_last)
  );

endmodule

@@ hdl/utf8sf_scan.sv @@
`timescale 1ns / 1ps
// Input register, sequence state and the per-byte decision of the UTF-8 filter.
// Depends on utf8sf_pkg; hands one batch of results to utf8sf_emit.
module utf8sf_scan #(
  parameter int COUNT_WIDTH = utf8sf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic [7:0]             in_byte,
  input  logic                   text_end,
  input  logic                   emit_free,
  output logic                   load,
  output utf8sf_pkg::batch_t     batch,
  output logic [COUNT_WIDTH-1:0] base
);

  logic                   ireg_valid;
  logic [7:0]             ireg_byte;
  logic                   ireg_last;

  logic [7:0]             held [3];
  logic [1:0]             held_count;
  logic [1:0]             held_count_next;
  logic                   text_stopped;
  logic                   text_stopped_next;
  logic [COUNT_WIDTH-1:0] write_count;
  logic [COUNT_WIDTH-1:0] write_count_next;

  logic                   held_we;
  logic [1:0]             held_widx;
  logic [7:0]             lo;
  logic [7:0]             hi;
  logic                   cont_ok;
  logic [2:0]             need;
  logic [COUNT_WIDTH:0]   count_sum;

  assign load       = ireg_valid && emit_free;
  assign byte_stall = ireg_valid && !emit_free;
  assign base       = write_count;

  // Second-byte limits only apply right after the lead byte.
  always_comb begin
    lo = utf8sf_pkg::CONT_LO;
    hi = utf8sf_pkg::CONT_HI;
    if (held_count == 2'd1) begin
      case (held[0])
        utf8sf_pkg::LEAD_E0: lo = utf8sf_pkg::E0_CONT_LO;
        utf8sf_pkg::LEAD_ED: hi = utf8sf_pkg::ED_CONT_HI;
        utf8sf_pkg::LEAD_F0: lo = utf8sf_pkg::F0_CONT_LO;
        utf8sf_pkg::LEAD_F4: hi = utf8sf_pkg::F4_CONT_HI;
        default: ;
      endcase
    end
  end

  assign need    = utf8sf_pkg::seq_len(held[0]);
  assign cont_ok = (held_count != 2'd0) && (ireg_byte >= lo) && (ireg_byte <= hi);

  always_comb begin
    held_count_next   = held_count;
    text_stopped_next = text_stopped;
    held_we           = 1'b0;
    held_widx         = 2'd0;
    batch.data        = {utf8sf_pkg::MAX_DATA{ireg_byte}};
    batch.n_data      = 3'd0;
    batch.end_mark    = ireg_last;
    if (!text_stopped) begin
      if (cont_ok) begin
        if ({1'b0, held_count} + 3'd1 >= need) begin
          // Sequence complete: release held bytes followed by this one.
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_count) begin
              batch.data[i] = held[i];
            end
          end
          batch.n_data    = {1'b0, held_count} + 3'd1;
          held_count_next = 2'd0;
        end else begin
          held_we         = 1'b1;
          held_widx       = held_count;
          held_count_next = held_count + 2'd1;
        end
      end else begin
        // Anything held is dropped and the byte is judged as a start byte.
        held_count_next = 2'd0;
        if (ireg_byte == utf8sf_pkg::BYTE_NUL) begin
          text_stopped_next = 1'b1;
        end else if (ireg_byte < utf8sf_pkg::BYTE_SPACE) begin
          if (ireg_byte == utf8sf_pkg::BYTE_TAB || ireg_byte == utf8sf_pkg::BYTE_LF ||
              ireg_byte == utf8sf_pkg::BYTE_CR) begin
            batch.n_data = 3'd1;
          end
        end else if (ireg_byte <= utf8sf_pkg::BYTE_DEL) begin
          batch.n_data = 3'd1;
        end else if (utf8sf_pkg::seq_len(ireg_byte) != 3'd1) begin
          held_we         = 1'b1;
          held_widx       = 2'd0;
          held_count_next = 2'd1;
        end
      end
    end
    if (ireg_last) begin
      held_count_next   = 2'd0;
      text_stopped_next = 1'b0;
    end
  end

  assign count_sum = {1'b0, write_count} + (COUNT_WIDTH + 1)'(batch.n_data);

  always_comb begin
    if (ireg_last) begin
      write_count_next = '0;
    end else if (count_sum[COUNT_WIDTH]) begin
      write_count_next = '1;
    end else begin
      write_count_next = count_sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid   <= 1'b0;
      held_count   <= 2'd0;
      text_stopped <= 1'b0;
      write_count  <= '0;
    end else begin
      if (byte_valid && !byte_stall) begin
        ireg_valid <= 1'b1;
      end else if (load) begin
        ireg_valid <= 1'b0;
      end
      if (load) begin
        held_count   <= held_count_next;
        text_stopped <= text_stopped_next;
        write_count  <= write_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      ireg_byte <= in_byte;
      ireg_last <= text_end;
    end
    if (load && held_we) begin
      held[held_widx] <= ireg_byte;
    end
  end

endmodule

@@ hdl/utf8sf_emit.sv @@
`timescale 1ns / 1ps
// Result register of the UTF-8 filter: holds one batch and presents its entries in order.
// Depends on utf8sf_pkg; fed by utf8sf_scan.
module utf8sf_emit #(
  parameter int COUNT_WIDTH = utf8sf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  utf8sf_pkg::batch_t               batch,
  input  logic [COUNT_WIDTH-1:0]           base,
  output logic                             emit_free,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       out_byte,
  output logic                             kind,
  output logic [utf8sf_pkg::LEN_WIDTH-1:0] written_length,
  output logic                             run_last
);

  localparam int LW = utf8sf_pkg::LEN_WIDTH;

  logic                   bvalid;
  logic [2:0]             idx;
  utf8sf_pkg::batch_t     held_batch;
  logic [COUNT_WIDTH-1:0] held_base;

  logic [2:0]             n_total;
  logic [2:0]             step;
  logic [COUNT_WIDTH:0]   len_sum;
  logic [COUNT_WIDTH-1:0] len_sat;

  assign n_total      = held_batch.n_data + {2'b00, held_batch.end_mark};
  assign run_last     = (idx == n_total - 3'd1);
  assign result_valid = bvalid;
  assign emit_free    = !bvalid || (!result_stall && run_last);

  // The end marker always follows the data bytes of its batch.
  assign kind     = (idx == held_batch.n_data);
  assign out_byte = kind ? 8'h00 : held_batch.data[idx[1:0]];

  // A data entry shows the count including itself; the end marker shows the total.
  assign step    = kind ? held_batch.n_data : idx + 3'd1;
  assign len_sum = {1'b0, held_base} + (COUNT_WIDTH + 1)'(step);
  assign len_sat = len_sum[COUNT_WIDTH] ? '1 : len_sum[COUNT_WIDTH-1:0];

  generate
    if (COUNT_WIDTH > LW) begin : g_clamp
      assign written_length = (|len_sat[COUNT_WIDTH-1:LW]) ? '1 : len_sat[LW-1:0];
    end else begin : g_extend
      assign written_length = LW'(len_sat);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= 3'd0;
    end else if (load) begin
      bvalid <= (batch.n_data != 3'd0) || batch.end_mark;
      idx    <= 3'd0;
    end else if (bvalid && !result_stall) begin
      if (run_last) begin
        bvalid <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_batch <= batch;
      held_base  <= base;
    end
  end

endmodule

@@ hdl/utf8sf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for utf8_sanitize_filter_core, attached by the bind below.
// Depends on utf8sf_pkg and the top level's ports.
module utf8sf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [7:0]                       out_byte,
  input logic                             kind,
  input logic [utf8sf_pkg::LEN_WIDTH-1:0] written_length,
  input logic                             run_last
);

  // A stalled result keeps its whole payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte) && $stable(kind) &&
      $stable(written_length) && $stable(run_last))
    else $error("stalled result changed");

  // The end marker is always the final result of its input byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> run_last)
    else $error("end marker not flagged as last result");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> out_byte == 8'h00)
    else $error("end marker carries a data byte");

  // A data byte is counted before it is shown, so its length is never zero.
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> written_length != '0)
    else $error("data result with zero written length");

endmodule

bind utf8_sanitize_filter_core utf8sf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .out_byte      (out_byte),
  .kind          (kind),
  .written_length(written_length),
  .run_last      (run_last)
);
